// ----- rtl/whp_pkg.sv -----
// ----------------------------------------------------------------------------
// whp_pkg
// Shared types and constants of the WAV header parser.
// ----------------------------------------------------------------------------
package whp_pkg;

    // Tags as they read in file order, first byte in the top bits
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_BODY_LEN = 32'd16;
    localparam logic [15:0] MS_PER_S     = 16'd1000;

    localparam int DUR_W  = 42;
    localparam int OUT_W  = 176;   // 173 payload bits, padded to bytes

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOT_RIFF = 3'd1,
        ST_NOT_WAVE = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_ZERO_FMT = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_MUL = 2'b01,
        OP_DIV = 2'b10
    } t_alu_op;

    // Parser event, valid in the cycle the byte is accepted
    typedef struct packed {
        logic    emit;     // result with status, no arithmetic
        logic    finish;   // both chunks found, run the duration sequence
        t_status status;
    } t_parse_evt;

    typedef struct packed {
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] size;
        logic [31:0] offset;
    } t_held;

endpackage

// ----- rtl/whp_arith_unit.sv -----
// ----------------------------------------------------------------------------
// whp_arith_unit
// Shared arithmetic: a 32x16 multiply or one restoring divide step.
// ----------------------------------------------------------------------------
module whp_arith_unit (
    input  whp_pkg::t_alu_op i_op,
    input  logic [31:0]      i_a,
    input  logic [15:0]      i_b,
    input  logic [31:0]      i_rem,
    input  logic             i_nbit,
    input  logic [31:0]      i_divisor,
    output logic [47:0]      o_prod,
    output logic [31:0]      o_rem,
    output logic             o_qbit
);
    import whp_pkg::*;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        fits;

    assign shifted = {i_rem, i_nbit};
    assign diff    = shifted - {1'b0, i_divisor};
    assign fits    = (shifted >= {1'b0, i_divisor});

    always_comb begin
        o_prod = 48'd0;
        o_rem  = i_rem;
        o_qbit = 1'b0;
        case (i_op)
            OP_MUL: begin
                o_prod = {16'd0, i_a} * {32'd0, i_b};
            end
            OP_DIV: begin
                o_qbit = fits;
                o_rem  = fits ? diff[31:0] : shifted[31:0];
            end
            default: begin
                o_prod = 48'd0;
            end
        endcase
    end

endmodule

// ----- rtl/whp_byte_parser.sv -----
// ----------------------------------------------------------------------------
// whp_byte_parser
// Byte-wide RIFF/WAVE chunk walker; captures fmt and data fields.
// ----------------------------------------------------------------------------
module whp_byte_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_byte,
    input  logic                i_first,
    input  logic                i_last,
    output whp_pkg::t_parse_evt o_evt,
    output whp_pkg::t_held      o_held
);
    import whp_pkg::*;

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_RIFF_TAG  = 10'b00_0000_0010,
        PH_RIFF_SIZE = 10'b00_0000_0100,
        PH_WAVE_TAG  = 10'b00_0000_1000,
        PH_CK_ID     = 10'b00_0001_0000,
        PH_CK_SIZE   = 10'b00_0010_0000,
        PH_FMT_LO    = 10'b00_0100_0000,
        PH_FMT_HI    = 10'b00_1000_0000,
        PH_SKIP      = 10'b01_0000_0000,
        PH_DONE      = 10'b10_0000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [23:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [31:0] r_skip, n_skip;
    logic [31:0] r_pos, n_pos;
    logic        r_fmt_seen, n_fmt_seen;
    logic        r_data_seen, n_data_seen;
    logic        r_is_fmt, n_is_fmt;
    logic        r_is_data, n_is_data;
    t_held       r_held, n_held;

    function automatic t_phase f_next_chunk(input logic [31:0] skip);
        f_next_chunk = (skip != 32'd0) ? PH_SKIP : PH_CK_ID;
    endfunction

    always_comb begin
        logic [31:0] word;
        logic [31:0] full;
        logic [31:0] dec;
        logic [3:0]  fpos;
        logic        stop;

        n_phase     = r_phase;
        n_idx       = r_idx;
        n_tag       = r_tag;
        n_len       = r_len;
        n_skip      = r_skip;
        n_pos       = r_pos;
        n_fmt_seen  = r_fmt_seen;
        n_data_seen = r_data_seen;
        n_is_fmt    = r_is_fmt;
        n_is_data   = r_is_data;
        n_held      = r_held;
        o_evt       = '0;
        stop        = 1'b0;
        word        = 32'd0;
        full        = 32'd0;
        dec         = 32'd0;
        fpos        = 4'd0;

        if (i_en) begin
            if (i_first) begin
                n_phase     = PH_RIFF_TAG;
                n_idx       = 3'd0;
                n_tag       = 24'd0;
                n_len       = 32'd0;
                n_skip      = 32'd0;
                n_pos       = 32'd0;
                n_fmt_seen  = 1'b0;
                n_data_seen = 1'b0;
                n_is_fmt    = 1'b0;
                n_is_data   = 1'b0;
                n_held      = '0;
            end

            case (n_phase)
                PH_RIFF_TAG, PH_WAVE_TAG, PH_CK_ID: begin
                    word  = {n_tag, i_byte};
                    n_tag = {n_tag[15:0], i_byte};
                    n_idx = n_idx + 3'd1;
                    if (n_idx == 3'd4) begin
                        n_idx = 3'd0;
                        n_tag = 24'd0;
                        case (n_phase)
                            PH_RIFF_TAG: begin
                                if (word != TAG_RIFF) begin
                                    o_evt.emit   = 1'b1;
                                    o_evt.status = ST_NOT_RIFF;
                                    n_phase      = PH_DONE;
                                    stop         = 1'b1;
                                end else begin
                                    n_phase = PH_RIFF_SIZE;
                                end
                            end
                            PH_WAVE_TAG: begin
                                if (word != TAG_WAVE) begin
                                    o_evt.emit   = 1'b1;
                                    o_evt.status = ST_NOT_WAVE;
                                    n_phase      = PH_DONE;
                                    stop         = 1'b1;
                                end else begin
                                    n_phase = PH_CK_ID;
                                end
                            end
                            default: begin
                                n_is_fmt  = (word == TAG_FMT);
                                n_is_data = (word == TAG_DATA);
                                n_len     = 32'd0;
                                n_phase   = PH_CK_SIZE;
                            end
                        endcase
                    end
                end
                PH_RIFF_SIZE, PH_CK_SIZE: begin
                    full = n_len;
                    full[{n_idx[1:0], 3'b000} +: 8] = i_byte;
                    n_len = full;
                    if (n_idx[1:0] == 2'd3) begin
                        n_idx = 3'd0;
                        if (n_phase == PH_RIFF_SIZE) begin
                            n_len   = 32'd0;
                            n_phase = PH_WAVE_TAG;
                        end else if (n_is_fmt) begin
                            n_skip  = (full > FMT_BODY_LEN) ? full - FMT_BODY_LEN : 32'd0;
                            n_phase = PH_FMT_LO;
                        end else if (n_is_data) begin
                            n_held.size   = full;
                            n_held.offset = n_pos + 32'd1;
                            n_data_seen   = 1'b1;
                            if (n_fmt_seen) begin
                                o_evt.finish = 1'b1;
                                n_phase      = PH_DONE;
                                stop         = 1'b1;
                            end else begin
                                n_skip  = full;
                                n_tag   = 24'd0;
                                n_len   = 32'd0;
                                n_phase = f_next_chunk(full);
                            end
                        end else begin
                            n_skip  = full;
                            n_tag   = 24'd0;
                            n_len   = 32'd0;
                            n_phase = f_next_chunk(full);
                        end
                    end else begin
                        n_idx = n_idx + 3'd1;
                    end
                end
                PH_FMT_LO, PH_FMT_HI: begin
                    fpos = {(n_phase == PH_FMT_HI), n_idx};
                    case (fpos)
                        4'd2:  n_held.channels[7:0]  = i_byte;
                        4'd3:  n_held.channels[15:8] = i_byte;
                        4'd4:  n_held.rate[7:0]      = i_byte;
                        4'd5:  n_held.rate[15:8]     = i_byte;
                        4'd6:  n_held.rate[23:16]    = i_byte;
                        4'd7:  n_held.rate[31:24]    = i_byte;
                        4'd14: n_held.bits[7:0]      = i_byte;
                        4'd15: n_held.bits[15:8]     = i_byte;
                        default: begin
                            n_held = n_held;
                        end
                    endcase
                    if (n_idx == 3'd7) begin
                        n_idx = 3'd0;
                        if (n_phase == PH_FMT_LO) begin
                            n_phase = PH_FMT_HI;
                        end else begin
                            n_fmt_seen = 1'b1;
                            if (n_data_seen) begin
                                o_evt.finish = 1'b1;
                                n_phase      = PH_DONE;
                                stop         = 1'b1;
                            end else begin
                                n_tag   = 24'd0;
                                n_len   = 32'd0;
                                n_phase = f_next_chunk(n_skip);
                            end
                        end
                    end else begin
                        n_idx = n_idx + 3'd1;
                    end
                end
                PH_SKIP: begin
                    dec    = n_skip - 32'd1;
                    n_skip = dec;
                    if (dec == 32'd0) begin
                        n_idx   = 3'd0;
                        n_tag   = 24'd0;
                        n_len   = 32'd0;
                        n_phase = PH_CK_ID;
                    end
                end
                default: begin
                    // idle or done: byte ignored
                    stop = 1'b1;
                end
            endcase

            if (!stop) begin
                n_pos = n_pos + 32'd1;
                if (i_last) begin
                    o_evt.emit   = 1'b1;
                    o_evt.status = ST_TRUNC;
                    n_phase      = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_idx       <= 3'd0;
            r_tag       <= 24'd0;
            r_len       <= 32'd0;
            r_skip      <= 32'd0;
            r_pos       <= 32'd0;
            r_fmt_seen  <= 1'b0;
            r_data_seen <= 1'b0;
            r_is_fmt    <= 1'b0;
            r_is_data   <= 1'b0;
            r_held      <= '0;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_tag       <= n_tag;
            r_len       <= n_len;
            r_skip      <= n_skip;
            r_pos       <= n_pos;
            r_fmt_seen  <= n_fmt_seen;
            r_data_seen <= n_data_seen;
            r_is_fmt    <= n_is_fmt;
            r_is_data   <= n_is_data;
            r_held      <= n_held;
        end
    end

    assign o_held = r_held;

endmodule

// ----- rtl/whp_duration_seq.sv -----
// ----------------------------------------------------------------------------
// whp_duration_seq
// Sequencer: bytes/s and duration on the shared arithmetic unit.
// ----------------------------------------------------------------------------
module whp_duration_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  whp_pkg::t_parse_evt i_evt,
    input  whp_pkg::t_held      i_held,
    input  logic                i_out_free,
    output logic                o_busy,
    output logic                o_load,
    output whp_pkg::t_status    o_status,
    output logic [41:0]         o_duration
);
    import whp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b00_0001,
        S_MUL_RC  = 6'b00_0010,
        S_MUL_BPS = 6'b00_0100,
        S_MUL_NUM = 6'b00_1000,
        S_DIV     = 6'b01_0000,
        S_EMIT    = 6'b10_0000
    } t_seq;

    localparam logic [5:0] DIV_LAST = 6'(DUR_W - 1);

    t_seq        r_state, n_state;
    t_status     r_status, n_status;
    logic [31:0] r_acc, n_acc;
    logic [41:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;

    t_alu_op     alu_op;
    logic [31:0] alu_a;
    logic [15:0] alu_b;
    logic [47:0] alu_prod;
    logic [31:0] alu_rem;
    logic        alu_qbit;

    whp_arith_unit u_alu (
        .i_op      (alu_op),
        .i_a       (alu_a),
        .i_b       (alu_b),
        .i_rem     (r_rem),
        .i_nbit    (r_quo[41]),
        .i_divisor (r_acc),
        .o_prod    (alu_prod),
        .o_rem     (alu_rem),
        .o_qbit    (alu_qbit)
    );

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_acc    = r_acc;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        o_load   = 1'b0;
        alu_op   = OP_MUL;
        alu_a    = i_held.rate;
        alu_b    = i_held.channels;

        case (r_state)
            S_IDLE: begin
                if (i_start && i_evt.emit) begin
                    n_status = i_evt.status;
                    n_quo    = 42'd0;
                    n_state  = S_EMIT;
                end else if (i_start && i_evt.finish) begin
                    n_state = S_MUL_RC;
                end
            end
            S_MUL_RC: begin
                n_acc   = alu_prod[31:0];
                n_state = S_MUL_BPS;
            end
            S_MUL_BPS: begin
                alu_a = r_acc;
                alu_b = {3'd0, i_held.bits[15:3]};
                n_acc = alu_prod[31:0];
                if (i_held.rate == 32'd0 || i_held.channels == 16'd0 ||
                    i_held.bits == 16'd0 || alu_prod[31:0] == 32'd0) begin
                    n_status = ST_ZERO_FMT;
                    n_quo    = 42'd0;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_MUL_NUM;
                end
            end
            S_MUL_NUM: begin
                alu_a   = i_held.size;
                alu_b   = MS_PER_S;
                n_quo   = alu_prod[41:0];
                n_rem   = 32'd0;
                n_cnt   = 6'd0;
                n_state = S_DIV;
            end
            S_DIV: begin
                alu_op = OP_DIV;
                n_quo  = {r_quo[40:0], alu_qbit};
                n_rem  = alu_rem;
                n_cnt  = r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) begin
                    n_status = ST_OK;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 6'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_acc    <= n_acc;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_status   = r_status;
    assign o_duration = r_quo;

endmodule

// ----- rtl/wav_header_parser_unit.sv -----
// ----------------------------------------------------------------------------
// wav_header_parser_unit
// RIFF/WAVE header parser: one file byte per request, at most one result per file.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the header is walked and skipped.
// An error or truncation result passes from the sequencer's emit state into
//   the output register once that is free. A good file first runs 3
//   multiplies and a 42-step divide on the shared unit, and s_axis_tready
//   stays low from the byte that completes both chunks until the result loads.
// Reset: i_rst_n, synchronous active low; parser idles until a first byte.
// ----------------------------------------------------------------------------
module wav_header_parser_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // byte stream in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
    input  logic         s_axis_tuser,   // [0] first_byte
    input  logic         s_axis_tlast,   // last_byte
    // result out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status, [18:3] channel_count, [50:19] sample_rate_hz,
    // [66:51] sample_bits, [98:67] payload_size, [130:99] payload_offset,
    // [172:131] duration_ms, [175:173] zero
    output logic [whp_pkg::OUT_W-1:0] m_axis_tdata
);
    import whp_pkg::*;

    logic               byte_acc;
    logic               seq_busy;
    logic               seq_load;
    logic               out_free;
    t_parse_evt         evt;
    t_held              held;
    t_status            res_status;
    logic [DUR_W-1:0]   res_duration;

    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    // Parser takes bytes only while no result is being formed
    assign s_axis_tready = !seq_busy;
    assign byte_acc      = s_axis_tvalid && s_axis_tready;

    whp_byte_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (byte_acc),
        .i_byte  (s_axis_tdata),
        .i_first (s_axis_tuser),
        .i_last  (s_axis_tlast),
        .o_evt   (evt),
        .o_held  (held)
    );

    // Output register is free when empty or drained this cycle
    assign out_free = !r_out_valid || m_axis_tready;

    whp_duration_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (byte_acc),
        .i_evt      (evt),
        .i_held     (held),
        .i_out_free (out_free),
        .o_busy     (seq_busy),
        .o_load     (seq_load),
        .o_status   (res_status),
        .o_duration (res_duration)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_load) begin
            r_out_data <= {3'd0, res_duration, held.offset, held.size,
                           held.bits, held.rate, held.channels, res_status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for wav_header_parser_unit. WAV images are built byte by
// byte (well-formed files with random content, plus bad tags, odd fmt sizes,
// unknown and repeated chunks, truncations, abandoned files and raw noise).
// They are streamed in bursts. A header model predicts the result of every
// file, and each result on the output stream is checked against it field by
// field.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import whp_pkg::*;

    // Parser phases of the header model
    typedef enum logic [9:0] {
        P_IDLE      = 10'b00_0000_0001,
        P_RIFF_TAG  = 10'b00_0000_0010,
        P_RIFF_SIZE = 10'b00_0000_0100,
        P_WAVE_TAG  = 10'b00_0000_1000,
        P_CK_ID     = 10'b00_0001_0000,
        P_CK_SIZE   = 10'b00_0010_0000,
        P_FMT_LO    = 10'b00_0100_0000,
        P_FMT_HI    = 10'b00_1000_0000,
        P_SKIP      = 10'b01_0000_0000,
        P_DONE      = 10'b10_0000_0000
    } t_parse_phase;

    // Receiver behavior, changed at random while the bench runs
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} t_rx_mode;

    // Result word as laid out on m_axis_tdata, top bits first
    typedef struct packed {
        logic [2:0]       pad;
        logic [DUR_W-1:0] duration_ms;
        logic [31:0]      payload_offset;
        logic [31:0]      payload_size;
        logic [15:0]      sample_bits;
        logic [31:0]      sample_rate_hz;
        logic [15:0]      channel_count;
        t_status          status;
    } t_header_result;

    // ------------------------------------------------------------------------
    // Header model and store of expected results
    // ------------------------------------------------------------------------
    class t_header_board;
        t_parse_phase   phase;
        logic [2:0]     byte_idx;
        logic [31:0]    tag;
        logic [31:0]    chunk_len;
        logic [31:0]    skip_left;
        logic [31:0]    file_pos;
        logic [31:0]    cur_id;
        bit             fmt_seen;
        bit             data_seen;
        logic [15:0]    channels;
        logic [31:0]    rate;
        logic [15:0]    bits;
        logic [31:0]    data_size;
        logic [31:0]    data_offset;
        t_header_result expected_results[$];
        int             bytes_taken;
        int             mismatches;

        function new();
            restart();
            bytes_taken = 0;
            mismatches = 0;
        endfunction

        function void restart();
            phase = P_IDLE;
            byte_idx = '0;
            tag = '0;
            chunk_len = '0;
            skip_left = '0;
            file_pos = '0;
            cur_id = '0;
            fmt_seen = 1'b0;
            data_seen = 1'b0;
            channels = '0;
            rate = '0;
            bits = '0;
            data_size = '0;
            data_offset = '0;
        endfunction

        function void emit(t_status st, logic [DUR_W-1:0] dur);
            t_header_result r;
            r.pad = '0;
            r.duration_ms = dur;
            r.payload_offset = data_offset;
            r.payload_size = data_size;
            r.sample_bits = bits;
            r.sample_rate_hz = rate;
            r.channel_count = channels;
            r.status = st;
            expected_results.push_back(r);
            phase = P_DONE;
        endfunction

        // Both chunks known: bytes per second wraps at 32 bits before the divide
        function void finish_duration();
            logic [31:0]      bps;
            logic [DUR_W-1:0] num;
            bps = rate * {16'b0, channels} * {16'b0, bits >> 3};
            if (rate == 0 || channels == 0 || bits == 0 || bps == 0) begin
                emit(ST_ZERO_FMT, '0);
            end else begin
                num = DUR_W'(data_size) * DUR_W'(MS_PER_S);
                emit(ST_OK, num / DUR_W'(bps));
            end
        endfunction

        function void next_chunk();
            byte_idx = '0;
            tag = '0;
            chunk_len = '0;
            phase = (skip_left != 0) ? P_SKIP : P_CK_ID;
        endfunction

        // One accepted request: byte, first-byte and last-byte flags
        function void take_byte(logic [7:0] b, bit first, bit last);
            logic [2:0] i;
            int         pos;
            bytes_taken++;
            if (first) begin
                restart();
                phase = P_RIFF_TAG;
            end
            if (phase == P_IDLE || phase == P_DONE)
                return;
            i = byte_idx;
            case (phase)
                P_RIFF_TAG, P_WAVE_TAG, P_CK_ID: begin
                    tag = {tag[23:0], b};
                    byte_idx = i + 3'd1;
                    if (i == 3'd3) begin
                        byte_idx = '0;
                        if (phase == P_RIFF_TAG) begin
                            if (tag != TAG_RIFF) begin
                                emit(ST_NOT_RIFF, '0);
                                return;
                            end
                            phase = P_RIFF_SIZE;
                        end else if (phase == P_WAVE_TAG) begin
                            if (tag != TAG_WAVE) begin
                                emit(ST_NOT_WAVE, '0);
                                return;
                            end
                            phase = P_CK_ID;
                        end else begin
                            cur_id = tag;
                            chunk_len = '0;
                            phase = P_CK_SIZE;
                        end
                        tag = '0;
                    end
                end
                P_RIFF_SIZE, P_CK_SIZE: begin
                    chunk_len[8*i[1:0] +: 8] = b;
                    byte_idx = i + 3'd1;
                    if (i == 3'd3) begin
                        byte_idx = '0;
                        if (phase == P_RIFF_SIZE) begin
                            chunk_len = '0;
                            phase = P_WAVE_TAG;
                        end else if (cur_id == TAG_FMT) begin
                            skip_left = (chunk_len > FMT_BODY_LEN) ?
                                        chunk_len - FMT_BODY_LEN : '0;
                            phase = P_FMT_LO;
                        end else if (cur_id == TAG_DATA) begin
                            data_size = chunk_len;
                            data_offset = file_pos + 32'd1;
                            data_seen = 1'b1;
                            if (fmt_seen) begin
                                finish_duration();
                                return;
                            end
                            skip_left = chunk_len;
                            next_chunk();
                        end else begin
                            skip_left = chunk_len;
                            next_chunk();
                        end
                    end
                end
                P_FMT_LO, P_FMT_HI: begin
                    // fmt body is always 16 bytes, whatever the size field says
                    pos = int'(i) + ((phase == P_FMT_HI) ? 8 : 0);
                    if (pos == 2) channels[7:0] = b;
                    else if (pos == 3) channels[15:8] = b;
                    else if (pos >= 4 && pos <= 7) rate[8*(pos-4) +: 8] = b;
                    else if (pos == 14) bits[7:0] = b;
                    else if (pos == 15) bits[15:8] = b;
                    byte_idx = i + 3'd1;
                    if (i == 3'd7) begin
                        if (phase == P_FMT_LO) begin
                            phase = P_FMT_HI;
                        end else begin
                            fmt_seen = 1'b1;
                            if (data_seen) begin
                                finish_duration();
                                return;
                            end
                            next_chunk();
                        end
                    end
                end
                default: begin
                    skip_left = skip_left - 32'd1;
                    if (skip_left == 0)
                        next_chunk();
                end
            endcase
            file_pos = file_pos + 32'd1;
            if (last)
                emit(ST_TRUNC, '0);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        endtask

        task check_result(logic [OUT_W-1:0] word);
            t_header_result got;
            t_header_result want;
            got = t_header_result'(word);
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result 0x%0h", word));
                return;
            end
            want = expected_results.pop_front();
            check_field("status", 64'(got.status), 64'(want.status));
            check_field("channel_count", 64'(got.channel_count), 64'(want.channel_count));
            check_field("sample_rate_hz", 64'(got.sample_rate_hz), 64'(want.sample_rate_hz));
            check_field("sample_bits", 64'(got.sample_bits), 64'(want.sample_bits));
            check_field("payload_size", 64'(got.payload_size), 64'(want.payload_size));
            check_field("payload_offset", 64'(got.payload_offset),
                        64'(want.payload_offset));
            check_field("duration_ms", 64'(got.duration_ms), 64'(want.duration_ms));
            check_field("pad", 64'(got.pad), 64'(want.pad));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and its ports
    // ------------------------------------------------------------------------
    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = '0;    // [7:0] byte_value
    logic             s_axis_tuser = 1'b0;  // [0] first_byte
    logic             s_axis_tlast = 1'b0;  // last_byte
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // [2:0] status, [18:3] channels, [50:19] rate, [66:51] bits,
    // [98:67] size, [130:99] offset, [172:131] duration_ms, [175:173] zero
    logic [OUT_W-1:0] m_axis_tdata;

    wav_header_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    t_header_board      board;
    logic [7:0]         file_q[$];    // image of the file being built
    int                 burst_left = 0;
    int                 hold_left = 0;    // long receiver hold-off, in cycles
    int                 mode_left = 0;
    t_rx_mode           rx_mode = RX_OPEN;
    bit                 draining = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard limit, far above the slowest legal run
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------------
    // Tags go out first character first
    function automatic void put_tag(logic [31:0] t);
        for (int k = 3; k >= 0; k--)
            file_q.push_back(t[8*k +: 8]);
    endfunction

    function automatic void put_le(logic [31:0] v, int n);
        for (int k = 0; k < n; k++)
            file_q.push_back(v[8*k +: 8]);
    endfunction

    function automatic void put_random(int n);
        for (int k = 0; k < n; k++)
            file_q.push_back(8'($urandom));
    endfunction

    function automatic void open_file();
        file_q.delete();
        put_tag(TAG_RIFF);
        put_le($urandom, 4);
        put_tag(TAG_WAVE);
    endfunction

    // fmt chunk: random format tag, byte rate and block align around the
    // captured fields; bytes past 16 only when the size says so
    function automatic void put_fmt(logic [31:0] size, logic [15:0] ch,
                                    logic [31:0] rate, logic [15:0] bits);
        put_tag(TAG_FMT);
        put_le(size, 4);
        put_le($urandom, 2);
        put_le(ch, 2);
        put_le(rate, 4);
        put_random(6);
        put_le(bits, 2);
        if (size > FMT_BODY_LEN)
            put_random(int'(size - FMT_BODY_LEN));
    endfunction

    function automatic void put_chunk(logic [31:0] id, logic [31:0] size, int body);
        put_tag(id);
        put_le(size, 4);
        put_random(body);
    endfunction

    // ------------------------------------------------------------------------
    // Stream drivers
    // ------------------------------------------------------------------------
    // One request; called at a rising edge, returns at the acceptance edge or
    // after the gap that follows it. Valid stays high inside a burst.
    task automatic offer_byte(logic [7:0] b, bit first, bit last);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        board.take_byte(b, first, last);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // Sends the image up to last_at, which carries tlast; a negative last_at
    // sends the whole image with no tlast (the file is abandoned). Tail bytes
    // follow as stray traffic, the final one with tlast.
    task automatic stream_file(int last_at, int tail);
        for (int k = 0; k < file_q.size(); k++) begin
            if (last_at >= 0 && k > last_at)
                break;
            offer_byte(file_q[k], k == 0, k == last_at);
        end
        for (int t = 0; t < tail; t++)
            offer_byte(8'($urandom), 1'b0, t == tail - 1);
    endtask

    task automatic good_file(logic [15:0] ch, logic [31:0] rate, logic [15:0] bits,
                             logic [31:0] size);
        open_file();
        put_fmt(FMT_BODY_LEN, ch, rate, bits);
        put_chunk(TAG_DATA, size, 0);
        stream_file(file_q.size() - 1, 0);
    endtask

    // Mostly well-formed files with random content; the rest broken or noise
    task automatic random_file();
        logic [15:0] ch;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] fmt_size;
        int          dsz;
        int          ending;
        open_file();
        if ($urandom_range(0, 19) == 0)
            file_q[$urandom_range(0, 11)] ^= 8'(1 << $urandom_range(0, 7));
        ch   = 16'($urandom_range(1, 8));
        rate = $urandom_range(1000, 192000);
        bits = 16'(8 * $urandom_range(1, 4));
        case ($urandom_range(0, 9))
            0: begin
                ch   = 16'($urandom);
                rate = $urandom;
                bits = 16'($urandom);
            end
            1: begin
                // zero format: one of the fields, or a product wrapping to zero
                case ($urandom_range(0, 3))
                    0: ch = '0;
                    1: rate = '0;
                    2: bits = 16'($urandom_range(0, 7));
                    default: begin
                        rate = 32'h4000_0000;
                        ch   = 16'd4;
                        bits = 16'd8;
                    end
                endcase
            end
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0: fmt_size = $urandom_range(0, 15);
            1: fmt_size = $urandom_range(17, 24);
            default: fmt_size = FMT_BODY_LEN;
        endcase
        if ($urandom_range(0, 2) == 0) begin
            dsz = $urandom_range(0, 10);
            put_chunk($urandom, dsz, dsz);
        end
        if ($urandom_range(0, 3) == 0) begin
            // data ahead of fmt: its payload is skipped, so keep it short
            dsz = $urandom_range(0, 12);
            put_chunk(TAG_DATA, dsz, dsz);
            if ($urandom_range(0, 3) == 0)
                put_chunk($urandom, 2, 2);
            put_fmt(fmt_size, ch, rate, bits);
        end else begin
            put_fmt(fmt_size, ch, rate, bits);
            if ($urandom_range(0, 9) == 0)
                put_fmt(FMT_BODY_LEN, 16'($urandom), $urandom, 16'($urandom));
            if ($urandom_range(0, 3) == 0)
                put_chunk($urandom, 1, 1);
            if ($urandom_range(0, 9) != 0)
                put_chunk(TAG_DATA, ($urandom_range(0, 1) == 0) ? $urandom
                                                                : $urandom_range(0, 1 << 20),
                          $urandom_range(0, 3));
        end
        ending = $urandom_range(0, 19);
        if (ending <= 13) begin
            stream_file(file_q.size() - 1,
                        ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        end else if (ending <= 16) begin
            stream_file($urandom_range(0, file_q.size() - 1), 0);
        end else if (ending == 17) begin
            file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
            stream_file(file_q.size() - 1, 0);
        end else if (ending == 18) begin
            stream_file(-1, 0);
        end else begin
            foreach (file_q[k])
                file_q[k] = 8'($urandom);
            stream_file(file_q.size() - 1, 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall pattern, long hold-off on request, open on drain
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (draining) begin
                m_axis_tready <= 1'b1;
            end else if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 5) == 0);
                    default:   m_axis_tready <= ((mode_left % 8) < 3);
                endcase
            end
        end
    end

    // Result checker: pre-edge values, sampled at the acceptance edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bytes with no file open are ignored, tlast included
        offer_byte(8'h00, 1'b0, 1'b0);
        offer_byte(8'hFF, 1'b0, 1'b1);
        offer_byte(8'h52, 1'b0, 1'b0);

        // nominal CD audio, one second of payload
        good_file(16'd2, 32'd44100, 16'd16, 32'd176400);
        // largest duration: one byte per second, biggest payload
        good_file(16'd1, 32'd1, 16'd8, 32'hFFFF_FFFF);
        // all fields at their top, bytes per second wraps but stays nonzero
        good_file(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);

        // zero format: zero rate, channels, bits, bits below 8, wrapped product
        good_file(16'd2, 32'd0, 16'd16, 32'd1000);
        good_file(16'd0, 32'd48000, 16'd16, 32'd1000);
        good_file(16'd2, 32'd48000, 16'd0, 32'd1000);
        good_file(16'd2, 32'd48000, 16'd7, 32'd1000);
        good_file(16'd2, 32'h8000_0000, 16'd8, 32'd1000);

        // data ahead of fmt, unknown chunks (one empty), long fmt chunk;
        // payload after the result and a last byte there are ignored
        open_file();
        put_chunk($urandom, 3, 3);
        put_chunk(TAG_DATA, 5, 5);
        put_chunk(32'h4C49_5354, 0, 0);
        put_fmt(18, 16'd1, 32'd8000, 16'd8);
        put_random(3);
        stream_file(file_q.size() - 1, 2);

        // short fmt size still reads the full body; empty data chunk
        open_file();
        put_fmt(4, 16'd2, 32'd22050, 16'd16);
        put_chunk(TAG_DATA, 0, 0);
        stream_file(file_q.size() - 1, 0);

        // a repeated fmt after the result is ignored; empty data chunk ahead of fmt
        open_file();
        put_chunk(TAG_DATA, 0, 0);
        put_fmt(16, 16'd1, 32'd1000, 16'd8);
        put_fmt(20, 16'd2, 32'd48000, 16'd24);
        stream_file(file_q.size() - 1, 0);

        // bad RIFF on the first and on the fourth byte, bad WAVE
        open_file();
        file_q[0] = 8'h72;
        stream_file(file_q.size() - 1, 0);
        open_file();
        file_q[3] = 8'h47;
        stream_file(file_q.size() - 1, 0);
        open_file();
        file_q[11] ^= 8'h80;
        put_fmt(16, 16'd1, 32'd8000, 16'd8);
        stream_file(file_q.size() - 1, 0);

        // truncation: single-byte file, bad tag on the last byte itself, a good
        // file with a short payload, inside fmt, and a file with no data chunk
        offer_byte(8'h52, 1'b1, 1'b1);
        open_file();
        file_q[3] = 8'h00;
        stream_file(3, 0);
        good_file(16'd2, 32'd44100, 16'd16, 32'd10);
        open_file();
        put_fmt(16, 16'd2, 32'd44100, 16'd16);
        put_chunk(TAG_DATA, 32'd100, 0);
        stream_file(30, 0);
        open_file();
        put_fmt(16, 16'd2, 32'd44100, 16'd16);
        stream_file(file_q.size() - 1, 0);

        // file dropped before any result, then a restart
        open_file();
        put_fmt(16, 16'd6, 32'd96000, 16'd24);
        stream_file(-1, 0);

        // long receiver hold-off while good files keep coming
        hold_left = 400;
        repeat (3)
            good_file(16'($urandom_range(1, 8)), $urandom_range(8000, 192000),
                      16'(8 * $urandom_range(1, 4)), $urandom);

        repeat (3)
            random_file();

        s_axis_tvalid <= 1'b0;
        draining = 1'b1;
        while (board.expected_results.size() != 0)
            @(posedge i_clk);
        // room for a late divide to show up as a stray result
        repeat (80) @(posedge i_clk);

        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/whp_pkg.sv
rtl/whp_arith_unit.sv
rtl/whp_byte_parser.sv
rtl/whp_duration_seq.sv
rtl/wav_header_parser_unit.sv
tb/tb_top.sv
